FILE: hw/rtl/pfls_pkg.sv
// ----------------------------------------------------------------------------
// pfls_pkg
// Shared types and constants for the push-front list with search.
// ----------------------------------------------------------------------------
package pfls_pkg;

	// List capacity and derived widths
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 5;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Operation codes
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	// Request payload
	typedef struct packed {
		logic [1:0]       opcode;
		logic [7:0]       char_value;
		logic [15:0]      line_tag;
		logic [POS_W-1:0] position;
	} req_t;

	// Response payload
	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [POS_W-1:0] found_position;
		logic [4:0]       entry_count;
		logic             list_empty;
	} rsp_t;

	// Control broadcast from the top level to every cell
	typedef struct packed {
		logic             push;
		logic             remove;
		logic [IDX_W-1:0] rem_idx;
		logic [7:0]       key;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/pfls_req_if.sv
// ----------------------------------------------------------------------------
// pfls_req_if
// Valid/ready channel carrying list requests.
// ----------------------------------------------------------------------------
interface pfls_req_if
	import pfls_pkg::*;
;
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/pfls_rsp_if.sv
// ----------------------------------------------------------------------------
// pfls_rsp_if
// Valid/ready channel carrying list responses.
// ----------------------------------------------------------------------------
interface pfls_rsp_if
	import pfls_pkg::*;
;
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/pfls_cell.sv
// ----------------------------------------------------------------------------
// pfls_cell
// One list slot: holds a character and line tag, shifts toward the back on
// push, toward the front on remove, and takes part in the first-match ripple.
// ----------------------------------------------------------------------------
module pfls_cell
	import pfls_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] idx,
	input  logic [7:0]       prev_char,
	input  logic [15:0]      prev_line,
	input  logic [7:0]       next_char,
	input  logic [15:0]      next_line,
	input  logic             hit_in,
	output logic [7:0]       char_out,
	output logic [15:0]      line_out,
	output logic             hit_out,
	output logic             first
);

	logic [7:0]  char_q;
	logic [15:0] line_q;
	logic        occupied;
	logic        match;
	logic        pull_next;

	// Slot holds a live entry when it sits below the count
	assign occupied  = {{(CNT_W-IDX_W){1'b0}}, idx} < ctrl.count;
	assign match     = occupied && (char_q == ctrl.key);
	assign hit_out   = hit_in | match;
	assign first     = match & ~hit_in;
	assign pull_next = ctrl.remove && (idx >= ctrl.rem_idx);

	// Slot storage; push and remove never come together, idle cycles hold
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			char_q <= prev_char;
			line_q <= prev_line;
		end else if (pull_next) begin
			char_q <= next_char;
			line_q <= next_line;
		end
	end

	assign char_out = char_q;
	assign line_out = line_q;

endmodule

FILE: hw/rtl/push_front_list_with_search.sv
// ----------------------------------------------------------------------------
// push_front_list_with_search
// Bounded ordered list with push-front, remove-at-position and find.
// ----------------------------------------------------------------------------
// Usage:
//   req is a valid/ready sink carrying opcode, char_value, line_tag and
//   position; rsp is a valid/ready source carrying status, found,
//   found_position, entry_count and list_empty. Every request yields exactly
//   one response, in order.
//   A row of DEPTH cells holds the list, position 1 in cell 0. A push shifts
//   every cell one place back, a remove pulls the cells at and behind the
//   position one place forward, and a find ripples a hit flag from the front
//   cell to the back cell to pick the first match.
//   Response: registered, it appears in the cycle after the request
//   transfer. Throughput: one request per cycle while responses are taken;
//   the cycle time is set by the compare-and-ripple chain through the cells.
//   A stalled response holds; a new request is still taken in the cycle the
//   pending response is taken. While the response is held and not taken,
//   req.ready is low.
//   Reset empties the list at once (count to zero); no clearing pass, cell
//   contents are never read before being written.
// ----------------------------------------------------------------------------
module push_front_list_with_search
	import pfls_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	pfls_req_if.sink     req,
	pfls_rsp_if.source   rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_next;
	logic             xfer;
	logic             is_push;
	logic             is_remove;
	logic             full;
	logic             empty;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             pos_ok;
	logic             do_push;
	logic             do_remove;
	cell_ctrl_t       ctrl;
	logic [7:0]       cell_char [DEPTH];
	logic [15:0]      cell_line [DEPTH];
	logic [DEPTH:0]   hit_chain;
	logic [DEPTH-1:0] first_vec;
	logic [POS_W-1:0] fpos;

	// Request decode
	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign xfer      = req.valid & req.ready;
	assign is_push   = req.data.opcode == OP_PUSH;
	assign is_remove = req.data.opcode == OP_REMOVE;
	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign pos_ext   = CMP_W'(req.data.position);
	assign cnt_ext   = CMP_W'(count_q);
	assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
	assign do_push   = xfer && is_push && !full;
	assign do_remove = xfer && is_remove && !empty && pos_ok;

	// Cell control broadcast
	always_comb begin
		ctrl.push    = do_push;
		ctrl.remove  = do_remove;
		ctrl.rem_idx = IDX_W'(pos_ext - CMP_W'(1));
		ctrl.key     = req.data.char_value;
		ctrl.count   = count_q;
	end

	// Row of cells
	assign hit_chain[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [7:0]  pc;
		logic [15:0] pl;
		logic [7:0]  nc;
		logic [15:0] nl;

		if (i == 0) begin : g_front
			assign pc = req.data.char_value;
			assign pl = req.data.line_tag;
		end else begin : g_mid
			assign pc = cell_char[i-1];
			assign pl = cell_line[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign nc = cell_char[i];
			assign nl = cell_line[i];
		end else begin : g_inner
			assign nc = cell_char[i+1];
			assign nl = cell_line[i+1];
		end

		pfls_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (IDX_W'(i)),
			.prev_char (pc),
			.prev_line (pl),
			.next_char (nc),
			.next_line (nl),
			.hit_in    (hit_chain[i]),
			.char_out  (cell_char[i]),
			.line_out  (cell_line[i]),
			.hit_out   (hit_chain[i+1]),
			.first     (first_vec[i])
		);
	end

	// First-match position from the one-hot vector
	always_comb begin
		fpos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_vec[i]) begin
				fpos = fpos | POS_W'(i + 1);
			end
		end
	end

	// Next count and response
	always_comb begin
		count_next = count_q;
		if (do_push) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_remove) begin
			count_next = count_q - CNT_W'(1);
		end

		rsp_next.status         = ST_OK;
		rsp_next.found          = 1'b0;
		rsp_next.found_position = '0;
		unique case (req.data.opcode)
			OP_PUSH: begin
				if (full) begin
					rsp_next.status = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					rsp_next.status = ST_EMPTY;
				end else if (!pos_ok) begin
					rsp_next.status = ST_BADPOS;
				end
			end
			OP_FIND: begin
				rsp_next.found          = hit_chain[DEPTH];
				rsp_next.found_position = fpos;
			end
			default: begin
			end
		endcase
		rsp_next.entry_count = 5'(CMP_W'(count_next));
		rsp_next.list_empty  = count_next == '0;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				count_q <= count_next;
			end
			if (req.ready) begin
				rsp_valid_q <= req.valid;
			end
		end
	end

	// Response payload register
	always_ff @(posedge clk) begin
		if (xfer) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule
